[sv/assert_macros.svh]
// Assertion macros shared by the filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked check, masked while reset is high
`define ASSERT_CHK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Clocked check that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`else

`define ASSERT_CHK(label, clk, rst, prop)
`define ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

[sv/fvw_pkg.sv]
// Shared constants and types of the FIR filter.
package fvw_pkg;

   localparam int DEFAULT_MAX_TAPS = 32;
   localparam int DATA_W           = 16;
   localparam int INDEX_W          = 5;
   localparam int CSR_W            = 6;
   localparam int FRAC_W           = 15;

   // Per-cell controls from the sequencer
   typedef struct packed {
      logic hist_en;   // take the left neighbour's sample (shift or rotate)
      logic coef_rot;  // take the right neighbour's coefficient
      logic coef_we;   // load the written coefficient
   } cell_ctrl_type;

   // Multiply-accumulate controls
   typedef struct packed {
      logic clear;     // start a new sum
      logic en;        // product of this cycle joins the sum
   } mac_ctrl_type;

endpackage

[sv/fir_filter_valid_window.sv]
// Top level of the FIR filter: tap cell chain, sequencer, accumulator and result register.
//
//   channel   direction  handshake               payload
//   req_      in         req_valid / req_stall   mode, start_req, coef_index, value
//   rsp_      out        rsp_valid / rsp_stall   filtered, saturated
//   csr_      in         csr_valid / csr_ready   data (tap count)
//
// A coefficient write, or a sample that leaves the window short, starts no sum.
// A sample that yields a result starts a sum on its way to the result register: the history
// ring turns MAX_TAPS places past the single MAC, the coefficient ring turns MAX_TAPS places
// from the first used tap, then the DRAIN and ROUND states drain the MAC into that register.
// Reset is synchronous and clears all cells at once; there is no clearing pass.
// A waiting result does not block the next transfer in; a finished sum waits while
// the result register is still held by rsp_stall.
`include "assert_macros.svh"

module fir_filter_valid_window #(
   parameter int MAX_TAPS = fvw_pkg::DEFAULT_MAX_TAPS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_mode,
   input  logic                               req_start_req,
   input  logic [fvw_pkg::INDEX_W-1:0]        req_coef_index,
   input  logic signed [fvw_pkg::DATA_W-1:0]  req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [fvw_pkg::DATA_W-1:0]  rsp_filtered,
   output logic                               rsp_saturated,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [fvw_pkg::CSR_W-1:0]          csr_data
);
   import fvw_pkg::*;

   localparam int TW = $clog2(MAX_TAPS + 1);
   localparam int SW = $clog2(2 * MAX_TAPS);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_ROUND = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [SW-1:0] step_ff, step_in;
   logic [TW-1:0] fill_ff, fill_in;
   logic [TW-1:0] taps_ff, taps_in;
   logic [TW-1:0] fill_base, fill_new;
   logic [SW-1:0] step_pre, step_end;

   logic req_take, smp_take, cw_take, fire;
   logic run_hist, run_coef, run_mac, out_free, out_load;

   logic signed [DATA_W-1:0] hist_q [MAX_TAPS];
   logic signed [DATA_W-1:0] coef_q [MAX_TAPS];
   logic signed [DATA_W-1:0] ring_in;
   cell_ctrl_type            cell_ctrl [MAX_TAPS];
   mac_ctrl_type             mac_ctrl;

   logic signed [DATA_W-1:0] mac_result;
   logic                     mac_sat;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_filtered_ff;
   logic                     rsp_saturated_ff;

   // input transfer decode
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign smp_take  = req_take && req_mode;
   assign cw_take   = req_take && !req_mode && (int'(req_coef_index) < MAX_TAPS);

   // fill count, saturating at the chain length
   assign fill_base = req_start_req ? '0 : fill_ff;
   assign fill_new  = (fill_base < TW'(MAX_TAPS)) ? fill_base + TW'(1) : fill_base;
   assign fill_in   = smp_take ? fill_new : fill_ff;
   assign fire      = smp_take && (fill_new >= taps_ff);

   // tap count register, held as the count in use; not written while a sum runs
   assign csr_ready = (state_ff == ST_IDLE);
   always_comb begin
      taps_in = taps_ff;
      if (csr_valid && csr_ready) begin
         if (csr_data == '0) begin
            taps_in = TW'(1);
         end else if (int'(csr_data) > MAX_TAPS) begin
            taps_in = TW'(MAX_TAPS);
         end else begin
            taps_in = TW'(csr_data);
         end
      end
   end

   // step window: history turns on steps 0..M-1, coefficients on pre..end
   assign step_pre = SW'(MAX_TAPS) - SW'(taps_ff);
   assign step_end = SW'(2 * MAX_TAPS - 1) - SW'(taps_ff);
   assign run_hist = (state_ff == ST_RUN) && (step_ff < SW'(MAX_TAPS));
   assign run_coef = (state_ff == ST_RUN) && (step_ff >= step_pre);
   assign run_mac  = run_hist && run_coef;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign out_load = (state_ff == ST_ROUND) && out_free;

   // sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (fire) begin
               state_in = ST_RUN;
               step_in  = '0;
            end
         end
         ST_RUN: begin
            step_in = step_ff + SW'(1);
            if (step_ff == step_end) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         fill_ff  <= '0;
         taps_ff  <= TW'(MAX_TAPS);
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         fill_ff  <= fill_in;
         taps_ff  <= taps_in;
      end
   end

   // cell chain: history shifts up (ring closes at the top), coefficients down
   assign ring_in = (state_ff == ST_RUN) ? hist_q[MAX_TAPS-1] : req_value;

   for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
      localparam int PREV = (k + MAX_TAPS - 1) % MAX_TAPS;
      localparam int NEXT = (k + 1) % MAX_TAPS;
      logic signed [DATA_W-1:0] left;

      if (k == 0) begin : g_head
         assign left = ring_in;
      end else begin : g_body
         assign left = hist_q[PREV];
      end

      assign cell_ctrl[k].hist_en  = smp_take || run_hist;
      assign cell_ctrl[k].coef_rot = run_coef;
      assign cell_ctrl[k].coef_we  = cw_take && (int'(req_coef_index) == k);

      fvw_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (cell_ctrl[k]),
         .hist_in  (left),
         .coef_in  (coef_q[NEXT]),
         .wr_data  (req_value),
         .hist_out (hist_q[k]),
         .coef_out (coef_q[k])
      );
   end

   // MAC taps the top of the history ring and the bottom of the coefficient ring
   assign mac_ctrl.clear = fire;
   assign mac_ctrl.en    = run_mac;

   fvw_mac #(
      .MAX_TAPS (MAX_TAPS)
   ) u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mac_ctrl),
      .sample (hist_q[MAX_TAPS-1]),
      .coef   (coef_q[0]),
      .result (mac_result),
      .sat    (mac_sat)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_filtered_ff  <= mac_result;
         rsp_saturated_ff <= mac_sat;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_filtered  = rsp_filtered_ff;
   assign rsp_saturated = rsp_saturated_ff;

   // checks
   `ASSERT_CHK(a_step_in_window, clock, reset, (state_ff == ST_RUN) |-> (step_ff <= step_end))
   `ASSERT_CHK(a_fill_bound, clock, reset, fill_ff <= TW'(MAX_TAPS))
   `ASSERT_CHK(a_taps_bound, clock, reset, (taps_ff != '0) && (taps_ff <= TW'(MAX_TAPS)))
   `ASSERT_CHK(a_round_loads, clock, reset, out_load |=> (rsp_valid_ff && (state_ff == ST_IDLE)))
   `ASSERT_CHK(a_mac_after_fire, clock, reset, fire |=> (state_ff == ST_RUN) && (step_ff == '0))

endmodule

[sv/fvw_cell.sv]
// One tap cell: a history sample and a coefficient, each passed to a neighbour.
module fvw_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  fvw_pkg::cell_ctrl_type         ctrl,
   input  logic signed [fvw_pkg::DATA_W-1:0] hist_in,
   input  logic signed [fvw_pkg::DATA_W-1:0] coef_in,
   input  logic signed [fvw_pkg::DATA_W-1:0] wr_data,
   output logic signed [fvw_pkg::DATA_W-1:0] hist_out,
   output logic signed [fvw_pkg::DATA_W-1:0] coef_out
);
   import fvw_pkg::*;

   logic signed [DATA_W-1:0] hist_ff, hist_in_nxt;
   logic signed [DATA_W-1:0] coef_ff, coef_in_nxt;

   // sample moves one place along the history line
   assign hist_in_nxt = ctrl.hist_en ? hist_in : hist_ff;

   // coefficient: a write wins over rotation
   always_comb begin
      coef_in_nxt = coef_ff;
      if (ctrl.coef_we) begin
         coef_in_nxt = wr_data;
      end else if (ctrl.coef_rot) begin
         coef_in_nxt = coef_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '0;
         coef_ff <= '0;
      end else begin
         hist_ff <= hist_in_nxt;
         coef_ff <= coef_in_nxt;
      end
   end

   assign hist_out = hist_ff;
   assign coef_out = coef_ff;

endmodule

[sv/fvw_mac.sv]
// Multiply-accumulate unit with rounding at bit 15 and 16-bit saturation.
module fvw_mac #(
   parameter int MAX_TAPS = fvw_pkg::DEFAULT_MAX_TAPS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  fvw_pkg::mac_ctrl_type             ctrl,
   input  logic signed [fvw_pkg::DATA_W-1:0] sample,
   input  logic signed [fvw_pkg::DATA_W-1:0] coef,
   output logic signed [fvw_pkg::DATA_W-1:0] result,
   output logic                              sat
);
   import fvw_pkg::*;

   localparam int PW = 2 * DATA_W;
   localparam int AW = PW + $clog2(MAX_TAPS) + 1;
   localparam int RW = AW + 1 - FRAC_W;
   localparam logic signed [RW-1:0]     POS_LIM = RW'(32767);
   localparam logic signed [RW-1:0]     NEG_LIM = RW'(-32768);
   localparam logic signed [AW:0]       HALF    = (AW + 1)'(16384);

   logic signed [PW-1:0] prod_ff, prod_in;
   logic                 prod_vld_ff, prod_vld_in;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic signed [AW:0]   biased;
   logic signed [RW-1:0] rnd;
   logic                 over_hi, over_lo;

   // product stage
   assign prod_in     = sample * coef;
   assign prod_vld_in = ctrl.en;

   // accumulate stage
   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + AW'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= ctrl.clear ? 1'b0 : prod_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // round half up, then clamp
   assign biased  = (AW + 1)'(acc_ff) + HALF;
   assign rnd     = $signed(biased[AW:FRAC_W]);
   assign over_hi = rnd > POS_LIM;
   assign over_lo = rnd < NEG_LIM;
   assign sat     = over_hi || over_lo;

   always_comb begin
      if (over_hi) begin
         result = 16'sh7FFF;
      end else if (over_lo) begin
         result = 16'sh8000;
      end else begin
         result = $signed(rnd[DATA_W-1:0]);
      end
   end

endmodule
